>>> rtl/dcp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the closest pair engine.
package dcp_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int VALUE_BITS_DEF = 16;

    localparam int OP_W   = 3;
    localparam int IDX_PW = 6;
    localparam int VAL_PW = 16;
    localparam int CNT_PW = 7;
    localparam int ST_W   = 2;
    localparam int DIST_W = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL   = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd4;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_FEW = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD = 2'd2;

    typedef enum logic [2:0] {
        ALR_I     = 3'd0,
        ALR_BASE  = 3'd1,
        ALR_BASE1 = 3'd2,
        ALR_LP    = 3'd3,
        ALR_LAST  = 3'd4
    } al_rsel_t;

    typedef enum logic [2:0] {
        ALW_INIT  = 3'd0,
        ALW_MOVE  = 3'd1,
        ALW_SWAPA = 3'd2,
        ALW_SWAPB = 3'd3,
        ALW_ADD   = 3'd4
    } al_wsel_t;

    typedef enum logic {
        VR_IDX = 1'b0,
        VR_AL  = 1'b1
    } val_rsel_t;

    typedef enum logic [1:0] {
        LPW_ADD  = 2'd0,
        LPW_MOVE = 2'd1,
        LPW_LIST = 2'd2
    } lp_wsel_t;

    typedef enum logic {
        NBR_AL   = 1'b0,
        NBR_BEST = 1'b1
    } nb_rsel_t;

    typedef enum logic {
        NBW_SEEK = 1'b0,
        NBW_LAST = 1'b1
    } nb_wsel_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_DEC  = 2'd1,
        CNT_INC  = 2'd2,
        CNT_SET  = 2'd3
    } cnt_op_t;

    typedef enum logic [2:0] {
        IX_HOLD  = 3'd0,
        IX_ZERO  = 3'd1,
        IX_BASE1 = 3'd2,
        IX_INC   = 3'd3,
        IX_SCAN  = 3'd4
    } idx_op_t;

    typedef enum logic [1:0] {
        BS_HOLD = 2'd0,
        BS_ZERO = 2'd1,
        BS_INC  = 2'd2
    } base_op_t;

    typedef enum logic [1:0] {
        END_HOLD  = 2'd0,
        END_COUNT = 2'd1,
        END_BCNT  = 2'd2
    } end_op_t;

    typedef enum logic [1:0] {
        RES_HOLD = 2'd0,
        RES_CODE = 2'd1,
        RES_FIND = 2'd2
    } res_op_t;

    typedef enum logic [1:0] {
        PIV_HOLD = 2'd0,
        PIV_AL   = 2'd1,
        PIV_IDX  = 2'd2
    } piv_op_t;

    // controller to datapath
    typedef struct packed {
        logic            latch;
        al_rsel_t        al_rsel;
        logic            al_we;
        al_wsel_t        al_wsel;
        val_rsel_t       val_rsel;
        logic            val_we;
        logic            lp_we;
        lp_wsel_t        lp_wsel;
        nb_rsel_t        nb_rsel;
        logic            nb_we;
        nb_wsel_t        nb_wsel;
        cnt_op_t         cnt_op;
        idx_op_t         idx_op;
        base_op_t        base_op;
        end_op_t         end_op;
        logic            scan_init;
        logic            scan_find;
        logic            q_ld;
        piv_op_t         piv_id_op;
        logic            piv_val_ld;
        res_op_t         res_op;
        logic [ST_W-1:0] res_code;
        logic            out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_bad;
        logic            cnt_bad;
        logic            few;
        logic            active;
        logic            i_done;
        logic            head_more;
        logic            base_done;
        logic            bcnt_zero;
        logic            nb_match;
        logic            scan_done;
    } sts_t;

endpackage

>>> rtl/dcp_dp.sv
// Datapath: point memories, list counters, pipelined nearest scan and result registers.
module dcp_dp
    import dcp_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [OP_W-1:0]          op,
    input  logic [IDX_PW-1:0]        point_index,
    input  logic signed [VAL_PW-1:0] point_value,
    input  logic [CNT_PW-1:0]        build_count,
    output logic [ST_W-1:0]          status,
    output logic [IDX_PW-1:0]        pair_first,
    output logic [IDX_PW-1:0]        pair_second,
    output logic [DIST_W-1:0]        pair_distance
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int MW    = VALUE_BITS + 1;
    localparam int NB_W  = IDX_W + MW;
    localparam logic [MW-1:0] FAR = {1'b1, {VALUE_BITS{1'b0}}};

    // storage
    logic signed [VALUE_BITS-1:0] val_mem [MAX_POINTS];
    logic [IDX_W-1:0]             al_mem  [MAX_POINTS];
    logic [IDX_W-1:0]             lp_mem  [MAX_POINTS];
    logic [NB_W-1:0]              nb_mem  [MAX_POINTS];

    logic signed [VALUE_BITS-1:0] val_rd_reg;
    logic [IDX_W-1:0]             al_rd_reg;
    logic [IDX_W-1:0]             lp_rd_reg;
    logic [NB_W-1:0]              nb_rd_reg;

    // latched word
    logic [OP_W-1:0]              op_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic signed [VALUE_BITS-1:0] val_in_reg;
    logic [CNT_W-1:0]             bcnt_reg;
    logic                         idx_bad_reg;
    logic                         cnt_bad_reg;

    // counters and working registers
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             i_reg;
    logic [CNT_W-1:0]             end_reg;
    logic [CNT_W-1:0]             base_reg;
    logic [IDX_W-1:0]             q_reg;
    logic [IDX_W-1:0]             piv_id_reg;
    logic signed [VALUE_BITS-1:0] piv_val_reg;

    // scan pipeline
    logic                         v1_reg;
    logic                         v2_reg;
    logic [IDX_W-1:0]             pos1_reg;
    logic [IDX_W-1:0]             pos2_reg;
    logic [IDX_W-1:0]             id2_reg;
    logic                         found_reg;
    logic [MW-1:0]                best_d_reg;
    logic [IDX_W-1:0]             best_id_reg;
    logic [IDX_W-1:0]             best_pos_reg;

    // result registers
    logic [ST_W-1:0]              res_status_reg;
    logic [IDX_PW-1:0]            res_first_reg;
    logic [IDX_PW-1:0]            res_second_reg;
    logic [DIST_W-1:0]            res_dist_reg;
    logic [ST_W-1:0]              out_status_reg;
    logic [IDX_PW-1:0]            out_first_reg;
    logic [IDX_PW-1:0]            out_second_reg;
    logic [DIST_W-1:0]            out_dist_reg;

    logic [CNT_W-1:0]             base1;
    logic [CNT_W-1:0]             count_m1;
    logic                         i_done;
    logic                         issue;
    logic [IDX_W-1:0]             al_raddr;
    logic [IDX_W-1:0]             al_waddr;
    logic [IDX_W-1:0]             al_wdata;
    logic [IDX_W-1:0]             val_raddr;
    logic [IDX_W-1:0]             lp_waddr;
    logic [IDX_W-1:0]             lp_wdata;
    logic [IDX_W-1:0]             nb_raddr;
    logic [IDX_W-1:0]             nb_waddr;
    logic [NB_W-1:0]              nb_wdata;
    logic signed [MW-1:0]         diff;
    logic [MW-1:0]                metric;
    logic                         take;
    logic [IDX_W-1:0]             nb_rd_id;
    logic [MW-1:0]                nb_rd_dist;

    assign base1      = base_reg + CNT_W'(1);
    assign count_m1   = count_reg - CNT_W'(1);
    assign i_done     = (i_reg >= end_reg);
    assign issue      = (cmd.idx_op == IX_SCAN) && !i_done;
    assign nb_rd_id   = nb_rd_reg[NB_W-1:MW];
    assign nb_rd_dist = nb_rd_reg[MW-1:0];

    // address and data selection
    always_comb
    begin
        case (cmd.al_rsel)
            ALR_I:     al_raddr = i_reg[IDX_W-1:0];
            ALR_BASE:  al_raddr = base_reg[IDX_W-1:0];
            ALR_BASE1: al_raddr = base1[IDX_W-1:0];
            ALR_LP:    al_raddr = lp_rd_reg;
            ALR_LAST:  al_raddr = count_m1[IDX_W-1:0];
            default:   al_raddr = i_reg[IDX_W-1:0];
        endcase

        case (cmd.al_wsel)
            ALW_INIT:
            begin
                al_waddr = i_reg[IDX_W-1:0];
                al_wdata = i_reg[IDX_W-1:0];
            end
            ALW_MOVE:
            begin
                al_waddr = q_reg;
                al_wdata = al_rd_reg;
            end
            ALW_SWAPA:
            begin
                al_waddr = best_pos_reg;
                al_wdata = al_rd_reg;
            end
            ALW_SWAPB:
            begin
                al_waddr = base1[IDX_W-1:0];
                al_wdata = best_id_reg;
            end
            ALW_ADD:
            begin
                al_waddr = count_reg[IDX_W-1:0];
                al_wdata = idx_reg;
            end
            default:
            begin
                al_waddr = i_reg[IDX_W-1:0];
                al_wdata = i_reg[IDX_W-1:0];
            end
        endcase

        val_raddr = (cmd.val_rsel == VR_AL) ? al_rd_reg : idx_reg;
        nb_raddr  = (cmd.nb_rsel == NBR_BEST) ? best_id_reg : al_rd_reg;

        case (cmd.lp_wsel)
            LPW_ADD:
            begin
                lp_waddr = idx_reg;
                lp_wdata = count_reg[IDX_W-1:0];
            end
            LPW_MOVE:
            begin
                lp_waddr = al_rd_reg;
                lp_wdata = q_reg;
            end
            LPW_LIST:
            begin
                lp_waddr = al_rd_reg;
                lp_wdata = i_reg[IDX_W-1:0];
            end
            default:
            begin
                lp_waddr = idx_reg;
                lp_wdata = count_reg[IDX_W-1:0];
            end
        endcase

        // lone point keeps itself at the far mark
        if (cmd.nb_wsel == NBW_LAST)
        begin
            nb_waddr = al_rd_reg;
            nb_wdata = {al_rd_reg, FAR};
        end
        else
        begin
            nb_waddr = piv_id_reg;
            nb_wdata = found_reg ? {best_id_reg, best_d_reg} : {piv_id_reg, FAR};
        end
    end

    // memories, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.val_we)
            val_mem[idx_reg] <= val_in_reg;
        if (cmd.al_we)
            al_mem[al_waddr] <= al_wdata;
        if (cmd.lp_we)
            lp_mem[lp_waddr] <= lp_wdata;
        if (cmd.nb_we)
            nb_mem[nb_waddr] <= nb_wdata;
        val_rd_reg <= val_mem[val_raddr];
        al_rd_reg  <= al_mem[al_raddr];
        lp_rd_reg  <= lp_mem[idx_reg];
        nb_rd_reg  <= nb_mem[nb_raddr];
    end

    // scan compare stage: gap to pivot, or stored distance on find
    always_comb
    begin
        diff   = MW'(piv_val_reg) - MW'(val_rd_reg);
        metric = cmd.scan_find ? nb_rd_dist : (diff[MW-1] ? MW'(-diff) : MW'(diff));
        take   = v2_reg && !(!cmd.scan_find && (id2_reg == piv_id_reg))
                 && (!found_reg || (metric < best_d_reg));
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (cmd.scan_init)
                found_reg <= 1'b0;
            else if (take)
                found_reg <= 1'b1;
            case (cmd.cnt_op)
                CNT_DEC:  count_reg <= count_m1;
                CNT_INC:  count_reg <= count_reg + CNT_W'(1);
                CNT_SET:  count_reg <= bcnt_reg;
                default:  count_reg <= count_reg;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= op;
            idx_reg     <= IDX_W'(point_index);
            val_in_reg  <= VALUE_BITS'(point_value);
            bcnt_reg    <= CNT_W'(build_count);
            idx_bad_reg <= (32'(point_index) >= 32'(MAX_POINTS));
            cnt_bad_reg <= (32'(build_count) > 32'(MAX_POINTS));
        end

        case (cmd.idx_op)
            IX_ZERO:  i_reg <= '0;
            IX_BASE1: i_reg <= base1;
            IX_INC:   i_reg <= i_reg + CNT_W'(1);
            IX_SCAN:  i_reg <= issue ? i_reg + CNT_W'(1) : i_reg;
            default:  i_reg <= i_reg;
        endcase

        case (cmd.base_op)
            BS_ZERO:  base_reg <= '0;
            BS_INC:   base_reg <= base1;
            default:  base_reg <= base_reg;
        endcase

        case (cmd.end_op)
            END_COUNT: end_reg <= count_reg;
            END_BCNT:  end_reg <= bcnt_reg;
            default:   end_reg <= end_reg;
        endcase

        case (cmd.piv_id_op)
            PIV_AL:   piv_id_reg <= al_rd_reg;
            PIV_IDX:  piv_id_reg <= idx_reg;
            default:  piv_id_reg <= piv_id_reg;
        endcase

        if (cmd.piv_val_ld)
            piv_val_reg <= val_rd_reg;
        if (cmd.q_ld)
            q_reg <= lp_rd_reg;

        // scan stages
        pos1_reg <= i_reg[IDX_W-1:0];
        pos2_reg <= pos1_reg;
        id2_reg  <= al_rd_reg;
        if (take)
        begin
            best_d_reg   <= metric;
            best_id_reg  <= id2_reg;
            best_pos_reg <= pos2_reg;
        end

        // result
        case (cmd.res_op)
            RES_CODE:
            begin
                res_status_reg <= cmd.res_code;
                res_first_reg  <= '0;
                res_second_reg <= '0;
                res_dist_reg   <= '0;
            end
            RES_FIND:
            begin
                res_status_reg <= ST_OK;
                res_first_reg  <= IDX_PW'(best_id_reg);
                res_second_reg <= IDX_PW'(nb_rd_id);
                res_dist_reg   <= (32'(best_d_reg) > 32'hFFFF) ? 16'hFFFF
                                  : DIST_W'(best_d_reg);
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_first_reg  <= res_first_reg;
            out_second_reg <= res_second_reg;
            out_dist_reg   <= res_dist_reg;
        end
    end

    // status toward the controller
    always_comb
    begin
        sts.op        = op_reg;
        sts.idx_bad   = idx_bad_reg;
        sts.cnt_bad   = cnt_bad_reg;
        sts.few       = (count_reg < CNT_W'(2));
        sts.active    = (CNT_W'(q_reg) < count_reg) && (al_rd_reg == idx_reg);
        sts.i_done    = i_done;
        sts.head_more = (base1 < end_reg);
        sts.base_done = (base_reg >= count_reg);
        sts.bcnt_zero = (bcnt_reg == '0);
        sts.nb_match  = (nb_rd_id == idx_reg);
        sts.scan_done = i_done && !v1_reg && !v2_reg;
    end

    assign status        = out_status_reg;
    assign pair_first    = out_first_reg;
    assign pair_second   = out_second_reg;
    assign pair_distance = out_dist_reg;

endmodule

>>> rtl/dcp_ctrl.sv
// Controller: sequences each operation through the datapath and runs both handshakes.
module dcp_ctrl
    import dcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [25:0] {
        S_IDLE  = 26'b1 << 0,
        S_DEC   = 26'b1 << 1,
        S_CHK1  = 26'b1 << 2,
        S_CHK2  = 26'b1 << 3,
        S_APIV  = 26'b1 << 4,
        S_AFIN  = 26'b1 << 5,
        S_DMOV  = 26'b1 << 6,
        S_DOUT  = 26'b1 << 7,
        S_DR1   = 26'b1 << 8,
        S_DR2   = 26'b1 << 9,
        S_DSW   = 26'b1 << 10,
        S_BINIT = 26'b1 << 11,
        S_BHEAD = 26'b1 << 12,
        S_BH1   = 26'b1 << 13,
        S_BH2   = 26'b1 << 14,
        S_BSW1  = 26'b1 << 15,
        S_BSW2  = 26'b1 << 16,
        S_BSW3  = 26'b1 << 17,
        S_BLAST = 26'b1 << 18,
        S_BL1   = 26'b1 << 19,
        S_BLP   = 26'b1 << 20,
        S_BLP1  = 26'b1 << 21,
        S_SCAN  = 26'b1 << 22,
        S_FRD   = 26'b1 << 23,
        S_FOUT  = 26'b1 << 24,
        S_DONE  = 26'b1 << 25
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end

            // first look at the word
            S_DEC:
            begin
                cmd.res_op   = RES_CODE;
                cmd.res_code = ST_OK;
                state_next   = S_DONE;
                case (sts.op)
                    OP_LOAD:
                    begin
                        if (sts.idx_bad)
                            cmd.res_code = ST_BAD;
                        else
                            cmd.val_we = 1'b1;
                    end
                    OP_BUILD:
                    begin
                        if (sts.cnt_bad)
                            cmd.res_code = ST_BAD;
                        else
                        begin
                            cmd.idx_op = IX_ZERO;
                            cmd.end_op = END_BCNT;
                            state_next = S_BINIT;
                        end
                    end
                    OP_ADD, OP_DEL:
                    begin
                        if (sts.idx_bad)
                            cmd.res_code = ST_BAD;
                        else
                            state_next = S_CHK1;
                    end
                    OP_FIND:
                    begin
                        if (sts.few)
                            cmd.res_code = ST_FEW;
                        else
                        begin
                            cmd.idx_op    = IX_ZERO;
                            cmd.end_op    = END_COUNT;
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.res_code = ST_BAD;
                    end
                endcase
            end

            // membership test: list position, then list entry there
            S_CHK1:
            begin
                cmd.q_ld    = 1'b1;
                cmd.al_rsel = ALR_LP;
                state_next  = S_CHK2;
            end

            S_CHK2:
            begin
                if ((sts.op == OP_ADD) == sts.active)
                begin
                    cmd.res_op   = RES_CODE;
                    cmd.res_code = ST_BAD;
                    state_next   = S_DONE;
                end
                else if (sts.op == OP_ADD)
                begin
                    cmd.val_rsel = VR_IDX;
                    state_next   = S_APIV;
                end
                else
                begin
                    cmd.al_rsel = ALR_LAST;
                    cmd.cnt_op  = CNT_DEC;
                    state_next  = S_DMOV;
                end
            end

            // add
            S_APIV:
            begin
                cmd.piv_val_ld = 1'b1;
                cmd.piv_id_op  = PIV_IDX;
                cmd.idx_op     = IX_ZERO;
                cmd.end_op     = END_COUNT;
                cmd.scan_init  = 1'b1;
                state_next     = S_SCAN;
            end

            S_AFIN:
            begin
                cmd.nb_we   = 1'b1;
                cmd.nb_wsel = NBW_SEEK;
                cmd.lp_we   = 1'b1;
                cmd.lp_wsel = LPW_ADD;
                cmd.al_we   = 1'b1;
                cmd.al_wsel = ALW_ADD;
                cmd.cnt_op  = CNT_INC;
                state_next  = S_DONE;
            end

            // delete: move last entry into the hole, then repair neighbours
            S_DMOV:
            begin
                cmd.al_we   = 1'b1;
                cmd.al_wsel = ALW_MOVE;
                cmd.lp_we   = 1'b1;
                cmd.lp_wsel = LPW_MOVE;
                cmd.base_op = BS_ZERO;
                state_next  = S_DOUT;
            end

            S_DOUT:
            begin
                if (sts.base_done)
                    state_next = S_DONE;
                else
                begin
                    cmd.al_rsel = ALR_BASE;
                    state_next  = S_DR1;
                end
            end

            S_DR1:
            begin
                cmd.piv_id_op = PIV_AL;
                cmd.nb_rsel   = NBR_AL;
                cmd.val_rsel  = VR_AL;
                state_next    = S_DR2;
            end

            S_DR2:
            begin
                if (sts.nb_match)
                begin
                    cmd.piv_val_ld = 1'b1;
                    cmd.idx_op     = IX_ZERO;
                    cmd.end_op     = END_COUNT;
                    cmd.scan_init  = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.base_op = BS_INC;
                    state_next  = S_DOUT;
                end
            end

            S_DSW:
            begin
                cmd.nb_we   = 1'b1;
                cmd.nb_wsel = NBW_SEEK;
                cmd.base_op = BS_INC;
                state_next  = S_DOUT;
            end

            // build: identity list, then conga-line pass, then position map
            S_BINIT:
            begin
                if (sts.i_done)
                begin
                    cmd.base_op = BS_ZERO;
                    state_next  = S_BHEAD;
                end
                else
                begin
                    cmd.al_we   = 1'b1;
                    cmd.al_wsel = ALW_INIT;
                    cmd.idx_op  = IX_INC;
                end
            end

            S_BHEAD:
            begin
                if (sts.head_more)
                begin
                    cmd.al_rsel = ALR_BASE;
                    state_next  = S_BH1;
                end
                else
                    state_next = S_BLAST;
            end

            S_BH1:
            begin
                cmd.piv_id_op = PIV_AL;
                cmd.val_rsel  = VR_AL;
                state_next    = S_BH2;
            end

            S_BH2:
            begin
                cmd.piv_val_ld = 1'b1;
                cmd.idx_op     = IX_BASE1;
                cmd.scan_init  = 1'b1;
                state_next     = S_SCAN;
            end

            S_BSW1:
            begin
                cmd.nb_we   = 1'b1;
                cmd.nb_wsel = NBW_SEEK;
                cmd.al_rsel = ALR_BASE1;
                state_next  = S_BSW2;
            end

            S_BSW2:
            begin
                cmd.al_we   = 1'b1;
                cmd.al_wsel = ALW_SWAPA;
                state_next  = S_BSW3;
            end

            S_BSW3:
            begin
                cmd.al_we   = 1'b1;
                cmd.al_wsel = ALW_SWAPB;
                cmd.base_op = BS_INC;
                state_next  = S_BHEAD;
            end

            S_BLAST:
            begin
                if (sts.bcnt_zero)
                begin
                    cmd.idx_op = IX_ZERO;
                    state_next = S_BLP;
                end
                else
                begin
                    cmd.al_rsel = ALR_BASE;
                    state_next  = S_BL1;
                end
            end

            S_BL1:
            begin
                cmd.nb_we   = 1'b1;
                cmd.nb_wsel = NBW_LAST;
                cmd.idx_op  = IX_ZERO;
                state_next  = S_BLP;
            end

            S_BLP:
            begin
                if (sts.i_done)
                begin
                    cmd.cnt_op = CNT_SET;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.al_rsel = ALR_I;
                    state_next  = S_BLP1;
                end
            end

            S_BLP1:
            begin
                cmd.lp_we   = 1'b1;
                cmd.lp_wsel = LPW_LIST;
                cmd.idx_op  = IX_INC;
                state_next  = S_BLP;
            end

            // shared nearest / minimum scan over the list
            S_SCAN:
            begin
                cmd.idx_op    = IX_SCAN;
                cmd.al_rsel   = ALR_I;
                cmd.val_rsel  = VR_AL;
                cmd.nb_rsel   = NBR_AL;
                cmd.scan_find = (sts.op == OP_FIND);
                if (sts.scan_done)
                begin
                    case (sts.op)
                        OP_BUILD: state_next = S_BSW1;
                        OP_ADD:   state_next = S_AFIN;
                        OP_DEL:   state_next = S_DSW;
                        OP_FIND:  state_next = S_FRD;
                        default:  state_next = S_DONE;
                    endcase
                end
            end

            // find: fetch partner of the winner
            S_FRD:
            begin
                cmd.nb_rsel = NBR_BEST;
                state_next  = S_FOUT;
            end

            S_FOUT:
            begin
                cmd.res_op = RES_FIND;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/dynamic_closest_pair_engine_core.sv
// Top level of the dynamic closest pair engine: controller, datapath and checks.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid / in_stall  | op, point_index, point_value, build_count
//   out     | output    | out_valid / out_stall| status, pair_first, pair_second, pair_distance
//
// One word at a time: in_stall is held from acceptance until the result is loaded into the
// output registers. Find, add and delete scan the active list; delete rescans once for each
// point whose neighbour was removed, and build scans the rest of the list from each head.
// The single list-scan pipeline and the one read port per memory set how long these take.
// Reset clears the controller, the active count and the output valid; the memories
// are not cleared. A stalled result stays put; the next word is taken meanwhile.
module dynamic_closest_pair_engine_core
    import dcp_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          op,
    input  logic [IDX_PW-1:0]        point_index,
    input  logic signed [VAL_PW-1:0] point_value,
    input  logic [CNT_PW-1:0]        build_count,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ST_W-1:0]          status,
    output logic [IDX_PW-1:0]        pair_first,
    output logic [IDX_PW-1:0]        pair_second,
    output logic [DIST_W-1:0]        pair_distance
);

    cmd_t cmd;
    sts_t sts;

    dcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    dcp_dp #(
        .MAX_POINTS (MAX_POINTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .point_index   (point_index),
        .point_value   (point_value),
        .build_count   (build_count),
        .status        (status),
        .pair_first    (pair_first),
        .pair_second   (pair_second),
        .pair_distance (pair_distance)
    );

    // a taken word holds off the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a word");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_FEW || status == ST_BAD))
        else $error("undefined status code");

    // failed words carry an all-zero pair
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |->
            pair_first == '0 && pair_second == '0 && pair_distance == '0)
        else $error("pair fields set on a failed word");

endmodule
